@@ rtl/twcf_pkg.sv @@
`timescale 1ns / 1ps

package twcf_pkg;

	// pending trailing-whitespace store
	localparam int PENDING_DEPTH = 16;
	localparam int PEND_PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PEND_CNT_W = $clog2(PENDING_DEPTH + 1);

	// command queue between front and back
	localparam int CMD_Q_DEPTH = 2;
	localparam int CQ_PTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
	localparam int CQ_CNT_W = $clog2(CMD_Q_DEPTH + 1);

	// mode_flags bit positions
	localparam int MODE_STRIP_ALL = 0;
	localparam int MODE_STRIP_LEAD = 1;
	localparam int MODE_TRIM_TRAIL = 2;
	localparam int MODE_SQUEEZE = 3;
	localparam int MODE_QUOTES = 4;
	localparam int MODE_UPPER = 5;
	localparam int MODE_LOWER = 6;
	localparam int MODE_DROP_CTRL = 7;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	typedef logic [1:0] cmd_kind_t;

	// command codes
	localparam cmd_kind_t CMD_PEND = 2'd0;     // hold a whitespace byte as pending
	localparam cmd_kind_t CMD_EMIT = 2'd1;     // flush pending, then emit byte
	localparam cmd_kind_t CMD_EMIT_END = 2'd2; // drop pending, emit final byte
	localparam cmd_kind_t CMD_MARK = 2'd3;     // drop pending, bare end marker

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	function automatic logic is_white(input logic [7:0] c);
		is_white = (c == CH_BLANK) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_ctrl(input logic [7:0] c);
		is_ctrl = (c < 8'h20) || (c == CH_DEL);
	endfunction

endpackage

@@ rtl/twcf_front.sv @@
`timescale 1ns / 1ps

module twcf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [7:0]        cfg_data,
	input  logic              accept,
	input  logic [7:0]        ch,
	input  logic              last,
	output logic              cmd_valid,
	output twcf_pkg::cmd_t    cmd
);
	import twcf_pkg::*;

	logic [7:0] mode_q;
	logic       in_quote_q;
	logic       quote_dbl_q;
	logic       white_run_q;
	logic       seen_nw_q;

	logic       in_quote_d;
	logic       quote_dbl_d;
	logic       white_run_d;
	logic       seen_nw_d;

	logic       have;
	logic [7:0] ob;
	logic [7:0] cc;
	logic       rwhite;
	logic       rlead;
	logic       trail;
	logic       reduce;
	logic       rctrl;
	logic       gen;

	assign rwhite = mode_q[MODE_STRIP_ALL];
	assign rlead  = mode_q[MODE_STRIP_LEAD];
	assign trail  = mode_q[MODE_TRIM_TRAIL];
	assign reduce = !rwhite && mode_q[MODE_SQUEEZE];
	assign rctrl  = mode_q[MODE_DROP_CTRL];

	always_comb begin
		have        = 1'b0;
		ob          = ch;
		cc          = ch;
		in_quote_d  = in_quote_q;
		quote_dbl_d = quote_dbl_q;
		white_run_d = white_run_q;
		seen_nw_d   = seen_nw_q;
		if (in_quote_q) begin
			have = 1'b1;
			if (ch == (quote_dbl_q ? CH_DQUOTE : CH_SQUOTE))
				in_quote_d = 1'b0;
		end else if (mode_q[MODE_QUOTES] && (ch == CH_DQUOTE || ch == CH_SQUOTE)) begin
			have        = 1'b1;
			white_run_d = 1'b0;
			seen_nw_d   = 1'b1;
			in_quote_d  = 1'b1;
			quote_dbl_d = (ch == CH_DQUOTE);
		end else if (is_white(ch)) begin
			if (rwhite || (rlead && !seen_nw_q)) begin
				have = 1'b0;
			end else if (reduce) begin
				if (!white_run_q) begin
					have        = 1'b1;
					ob          = CH_BLANK;
					white_run_d = 1'b1;
				end
			end else if (!(rctrl && ch != CH_BLANK)) begin
				have = 1'b1;
			end
		end else if (is_ctrl(ch)) begin
			white_run_d = 1'b0;
			seen_nw_d   = 1'b1;
			have        = !rctrl;
		end else begin
			white_run_d = 1'b0;
			seen_nw_d   = 1'b1;
			// upper first, then lower, so lower wins
			if (!ch[7]) begin
				if (mode_q[MODE_UPPER] && cc >= 8'h61 && cc <= 8'h7A)
					cc = cc - CASE_DELTA;
				if (mode_q[MODE_LOWER] && cc >= 8'h41 && cc <= 8'h5A)
					cc = cc + CASE_DELTA;
			end
			have = 1'b1;
			ob   = cc;
		end

		if (last) begin
			in_quote_d  = 1'b0;
			quote_dbl_d = 1'b0;
			white_run_d = 1'b0;
			seen_nw_d   = 1'b0;
		end
	end

	// classify into one back-end command, or none for a dropped byte that is not last
	always_comb begin
		gen       = 1'b1;
		cmd.data  = ob;
		cmd.kind  = CMD_EMIT;
		if (have && trail && is_white(ob)) begin
			cmd.kind = last ? CMD_MARK : CMD_PEND;
			if (last)
				cmd.data = 8'h00;
		end else if (have) begin
			cmd.kind = last ? CMD_EMIT_END : CMD_EMIT;
		end else begin
			cmd.kind = CMD_MARK;
			cmd.data = 8'h00;
			gen      = last;
		end
	end

	assign cmd_valid = accept && gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			in_quote_q  <= 1'b0;
			quote_dbl_q <= 1'b0;
			white_run_q <= 1'b0;
			seen_nw_q   <= 1'b0;
		end else begin
			if (cfg_valid)
				mode_q <= cfg_data;
			if (accept) begin
				in_quote_q  <= in_quote_d;
				quote_dbl_q <= quote_dbl_d;
				white_run_q <= white_run_d;
				seen_nw_q   <= seen_nw_d;
			end
		end
	end

endmodule

@@ rtl/twcf_cmd_queue.sv @@
`timescale 1ns / 1ps

module twcf_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  twcf_pkg::cmd_t    wr_cmd,
	output logic              full,
	input  logic              rd_en,
	output logic              rd_valid,
	output twcf_pkg::cmd_t    rd_cmd
);
	import twcf_pkg::*;

	cmd_t                slot_q [CMD_Q_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                do_wr;
	logic                do_rd;

	function automatic logic [CQ_PTR_W-1:0] cq_inc(input logic [CQ_PTR_W-1:0] p);
		cq_inc = (p == CQ_PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (cnt_q == CQ_CNT_W'(CMD_Q_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= cq_inc(wr_ptr_q);
			if (do_rd)
				rd_ptr_q <= cq_inc(rd_ptr_q);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ rtl/twcf_back.sv @@
`timescale 1ns / 1ps

module twcf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  twcf_pkg::cmd_t    cmd,
	output logic              cmd_take,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        out_ch,
	output logic              has_char,
	output logic              end_of_string,
	output logic              overflow
);
	import twcf_pkg::*;

	logic [7:0]            pend_mem [PENDING_DEPTH];
	logic [PEND_PTR_W-1:0] head_q;
	logic [PEND_PTR_W-1:0] tail_q;
	logic [PEND_CNT_W-1:0] pend_cnt_q;

	logic       out_valid_q;
	logic [7:0] out_ch_q;
	logic       out_has_q;
	logic       out_end_q;
	logic       out_ovf_q;

	logic       out_free;
	logic       load;
	logic [7:0] ld_ch;
	logic       ld_has;
	logic       ld_end;
	logic       ld_ovf;
	logic       pend_wr;
	logic       head_adv;
	logic       cnt_inc;
	logic       cnt_dec;
	logic       clear;
	logic       store_full;

	function automatic logic [PEND_PTR_W-1:0] pp_inc(input logic [PEND_PTR_W-1:0] p);
		pp_inc = (p == PEND_PTR_W'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign out_free   = !out_valid_q || pop;
	assign store_full = (pend_cnt_q == PEND_CNT_W'(PENDING_DEPTH));

	always_comb begin
		cmd_take = 1'b0;
		load     = 1'b0;
		ld_ch    = cmd.data;
		ld_has   = 1'b1;
		ld_end   = 1'b0;
		ld_ovf   = 1'b0;
		pend_wr  = 1'b0;
		head_adv = 1'b0;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		clear    = 1'b0;
		if (cmd_valid) begin
			unique case (cmd.kind)
				CMD_PEND: begin
					if (store_full) begin
						// oldest pending byte forced out, new one appended
						if (out_free) begin
							load     = 1'b1;
							ld_ch    = pend_mem[head_q];
							ld_ovf   = 1'b1;
							head_adv = 1'b1;
							pend_wr  = 1'b1;
							cmd_take = 1'b1;
						end
					end else begin
						pend_wr  = 1'b1;
						cnt_inc  = 1'b1;
						cmd_take = 1'b1;
					end
				end
				CMD_EMIT: begin
					if (out_free) begin
						load = 1'b1;
						if (pend_cnt_q != '0) begin
							ld_ch    = pend_mem[head_q];
							head_adv = 1'b1;
							cnt_dec  = 1'b1;
						end else begin
							cmd_take = 1'b1;
						end
					end
				end
				CMD_EMIT_END: begin
					if (out_free) begin
						load     = 1'b1;
						ld_end   = 1'b1;
						clear    = 1'b1;
						cmd_take = 1'b1;
					end
				end
				CMD_MARK: begin
					if (out_free) begin
						load     = 1'b1;
						ld_ch    = 8'h00;
						ld_has   = 1'b0;
						ld_end   = 1'b1;
						clear    = 1'b1;
						cmd_take = 1'b1;
					end
				end
				default: begin
					cmd_take = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pend_wr)
			pend_mem[tail_q] <= cmd.data;
		if (load) begin
			out_ch_q  <= ld_ch;
			out_has_q <= ld_has;
			out_end_q <= ld_end;
			out_ovf_q <= ld_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			pend_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				head_q     <= '0;
				tail_q     <= '0;
				pend_cnt_q <= '0;
			end else begin
				if (head_adv)
					head_q <= pp_inc(head_q);
				if (pend_wr)
					tail_q <= pp_inc(tail_q);
				if (cnt_inc)
					pend_cnt_q <= pend_cnt_q + 1'b1;
				else if (cnt_dec)
					pend_cnt_q <= pend_cnt_q - 1'b1;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	assign empty         = !out_valid_q;
	assign out_ch        = out_ch_q;
	assign has_char      = out_has_q;
	assign end_of_string = out_end_q;
	assign overflow      = out_ovf_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= PEND_CNT_W'(PENDING_DEPTH))
		else $error("pending count above store depth");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ld_end) |=> (pend_cnt_q == '0 && head_q == tail_q))
		else $error("pending store not emptied at end of string");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ld_ovf) |-> (store_full && !ld_end && ld_has))
		else $error("overflow result without a full store");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> $stable(out_ch_q) && $stable(out_end_q))
		else $error("result register changed while held");

endmodule

@@ rtl/text_whitespace_case_filter_unit.sv @@
`timescale 1ns / 1ps
// a byte's command is registered in the queue, then its result in the back-end result register
// throughput: one byte per cycle while the queue is not full; each flushed pending byte
// takes its own load of the single result register, which holds until its result is popped
// a short two-entry command queue lets the front take bytes while the back end flushes
// reset clears mode_flags, quote/run state, queue and pending pointers; store data is not cleared

module text_whitespace_case_filter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_ch,
	output logic       has_char,
	output logic       end_of_string,
	output logic       overflow,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import twcf_pkg::*;

	logic accept;
	logic f_cmd_valid;
	cmd_t f_cmd;
	logic q_valid;
	cmd_t q_cmd;
	logic q_take;

	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	twcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.ch        (ch),
		.last      (last),
		.cmd_valid (f_cmd_valid),
		.cmd       (f_cmd)
	);

	twcf_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (f_cmd_valid),
		.wr_cmd   (f_cmd),
		.full     (full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd)
	);

	twcf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (q_valid),
		.cmd           (q_cmd),
		.cmd_take      (q_take),
		.pop           (pop),
		.empty         (empty),
		.out_ch        (out_ch),
		.has_char      (has_char),
		.end_of_string (end_of_string),
		.overflow      (overflow)
	);

endmodule

@@ verif/tb_text_whitespace_case_filter_unit.sv @@
`timescale 1ns / 1ps

module tb_text_whitespace_case_filter_unit;
	import twcf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       has_char;
		logic       eos;
		logic       ovf;
	} text_out_t;

	typedef logic [7:0] text_t[$];

	class text_norm_sb;
		logic [7:0] mode;
		bit         in_quote;
		bit         quote_dq;
		bit         white_run;
		bit         seen_text;
		logic [7:0] held_white[$];
		text_out_t  norm_q[$];
		int unsigned errors;

		function new();
			mode = '0;
			errors = 0;
			clear_string();
		endfunction

		function void clear_string();
			in_quote = 0;
			quote_dq = 0;
			white_run = 0;
			seen_text = 0;
			held_white.delete();
		endfunction

		function bit blank_class(logic [7:0] c);
			return c == CH_BLANK || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		function bit control_class(logic [7:0] c);
			return c < 8'h20 || c == CH_DEL;
		endfunction

		function void add_out(logic [7:0] d, logic h, logic e, logic o);
			text_out_t r;
			r.data = d;
			r.has_char = h;
			r.eos = e;
			r.ovf = o;
			norm_q.push_back(r);
		endfunction

		// works out the normalized bytes that one source byte releases
		function void note_byte(logic [7:0] c, logic l);
			bit strip_all, lead, trail, squeeze, quotes, drop_ctrl, have;
			logic [7:0] ob, cc;
			int produced;
			strip_all = mode[MODE_STRIP_ALL];
			lead = mode[MODE_STRIP_LEAD];
			trail = mode[MODE_TRIM_TRAIL];
			squeeze = !strip_all && mode[MODE_SQUEEZE];
			quotes = mode[MODE_QUOTES];
			drop_ctrl = mode[MODE_DROP_CTRL];
			have = 0;
			ob = '0;
			cc = c;
			produced = norm_q.size();

			if (in_quote) begin
				have = 1;
				ob = c;
				if (c == (quote_dq ? CH_DQUOTE : CH_SQUOTE))
					in_quote = 0;
			end else if (quotes && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
				have = 1;
				ob = c;
				white_run = 0;
				seen_text = 1;
				in_quote = 1;
				quote_dq = (c == CH_DQUOTE);
			end else if (blank_class(c)) begin
				if (strip_all || (lead && !seen_text)) begin
					have = 0;
				end else if (squeeze) begin
					if (!white_run) begin
						have = 1;
						ob = CH_BLANK;
						white_run = 1;
					end
				end else if (!(drop_ctrl && c != CH_BLANK)) begin
					have = 1;
					ob = c;
				end
			end else if (control_class(c)) begin
				white_run = 0;
				seen_text = 1;
				if (!drop_ctrl) begin
					have = 1;
					ob = c;
				end
			end else begin
				white_run = 0;
				seen_text = 1;
				// case folding only for 7-bit letters, lower applied last
				if (c < 8'h80) begin
					if (mode[MODE_UPPER] && cc >= 8'h61 && cc <= 8'h7A)
						cc = cc - CASE_DELTA;
					if (mode[MODE_LOWER] && cc >= 8'h41 && cc <= 8'h5A)
						cc = cc + CASE_DELTA;
				end
				have = 1;
				ob = cc;
			end

			if (have) begin
				if (trail && blank_class(ob)) begin
					if (!l) begin
						if (held_white.size() >= PENDING_DEPTH)
							add_out(held_white.pop_front(), 1'b1, 1'b0, 1'b1);
						held_white.push_back(ob);
					end
				end else begin
					if (!l) begin
						while (held_white.size() != 0)
							add_out(held_white.pop_front(), 1'b1, 1'b0, 1'b0);
					end
					add_out(ob, 1'b1, l, 1'b0);
				end
			end

			if (l) begin
				// bare end marker when the string released nothing on its last byte
				if (norm_q.size() == produced)
					add_out(8'h00, 1'b0, 1'b1, 1'b0);
				clear_string();
			end
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(text_out_t got);
			text_out_t want;
			if (norm_q.size() == 0) begin
				report($sformatf("unexpected result out_ch=%h has_char=%b eos=%b ovf=%b",
					got.data, got.has_char, got.eos, got.ovf));
			end else begin
				want = norm_q.pop_front();
				if (got.data !== want.data)
					report($sformatf("out_ch %h, want %h", got.data, want.data));
				if (got.has_char !== want.has_char)
					report($sformatf("has_char %b, want %b", got.has_char, want.has_char));
				if (got.eos !== want.eos)
					report($sformatf("end_of_string %b, want %b", got.eos, want.eos));
				if (got.ovf !== want.ovf)
					report($sformatf("overflow %b, want %b", got.ovf, want.ovf));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] ch = '0;
	logic       last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_ch;
	logic       has_char;
	logic       end_of_string;
	logic       overflow;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	text_norm_sb sb = new();
	int send_idle = 20;
	int pop_idle = 71;
	int quiet_cycles = 0;

	text_whitespace_case_filter_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.ch           (ch),
		.last         (last),
		.empty        (empty),
		.pop          (pop),
		.out_ch       (out_ch),
		.has_char     (has_char),
		.end_of_string(end_of_string),
		.overflow     (overflow),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= pop_idle);
		end
	end

	// transaction monitor and stall watchdog
	always @(posedge clk) begin : mon
		text_out_t got;
		bit moved;
		moved = 0;
		if (push && !full) begin
			sb.note_byte(ch, last);
			moved = 1;
		end
		if (pop && !empty) begin
			got.data = out_ch;
			got.has_char = has_char;
			got.eos = end_of_string;
			got.ovf = overflow;
			sb.check_result(got);
			moved = 1;
		end
		if (cfg_valid && cfg_ready) begin
			sb.mode = cfg_data;
			moved = 1;
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		if ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		push <= 1'b1;
		ch <= b;
		last <= l;
		do @(posedge clk); while (full);
	endtask

	task automatic send_text(input text_t text, input bit close);
		foreach (text[i])
			send_byte(text[i], close && (i == text.size() - 1));
	endtask

	// mode changes only once every released byte has come out
	task automatic set_mode(input logic [7:0] m);
		push <= 1'b0;
		while (sb.norm_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] white_byte();
		return $urandom_range(1) ? CH_BLANK : 8'($urandom_range(9, 13));
	endfunction

	function automatic logic [7:0] letter_byte();
		if ($urandom_range(3) == 0)
			return 8'($urandom_range(33, 126));
		return $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
	endfunction

	// a string built from words, white runs, quoted spans, control and raw bytes
	task automatic send_random_string(input int len, input bit close, output int sent);
		text_t text;
		int seg_len;
		logic [7:0] q;
		while (text.size() < len) begin
			case ($urandom_range(11))
				0, 1, 2, 3: begin
					seg_len = $urandom_range(1, 6);
					repeat (seg_len) text.push_back(letter_byte());
				end
				4, 5, 6: begin
					seg_len = $urandom_range(1, 3);
					repeat (seg_len) text.push_back(white_byte());
				end
				7: begin
					seg_len = $urandom_range(16, 24);
					repeat (seg_len) text.push_back(white_byte());
				end
				8: begin
					q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
					text.push_back(q);
					seg_len = $urandom_range(0, 5);
					repeat (seg_len) begin
						case ($urandom_range(4))
							0: text.push_back(white_byte());
							1: text.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
							default: text.push_back(letter_byte());
						endcase
					end
					if ($urandom_range(3) != 0)
						text.push_back(q);
				end
				9: text.push_back($urandom_range(7) == 0 ? CH_DEL : 8'($urandom_range(0, 31)));
				default: text.push_back(8'($urandom_range(255)));
			endcase
		end
		send_text(text, close);
		sent = text.size();
	endtask

	initial begin
		text_t msg;
		int idle_plan[3][2];
		int count;
		int sent;
		logic [7:0] m;

		idle_plan = '{'{20, 71}, '{71, 20}, '{0, 0}};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero byte and top byte pass untouched
		set_mode(8'h00);
		msg = {8'h00, 8'hFF};
		send_text(msg, 1'b1);

		// leading strip, trailing trim, control drop; last white leaves a bare marker
		set_mode(8'h86);
		msg = {8'h20, 8'h01, 8'h61, 8'h20, 8'h09};
		send_text(msg, 1'b1);

		// all-white string under trim
		set_mode(8'h04);
		msg = {8'h20, 8'h20};
		send_text(msg, 1'b1);

		// squeeze, quoted spans, upper case
		set_mode(8'h38);
		msg = {8'h61, 8'h20, 8'h20, 8'h22, 8'h78, 8'h20, 8'h22, 8'h27, 8'h62};
		send_text(msg, 1'b1);

		// strip all with both case bits: lower wins
		set_mode(8'h61);
		msg = {8'h41, 8'h7A, 8'h20, 8'h7F};
		send_text(msg, 1'b1);

		// trim switched off with whitespace still held
		set_mode(8'h04);
		msg = {8'h61, 8'h20, 8'h20};
		send_text(msg, 1'b0);
		set_mode(8'h00);
		msg = {8'h62};
		send_text(msg, 1'b1);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = idle_plan[ph][0];
			pop_idle = idle_plan[ph][1];
			for (int sub = 0; sub < 4; sub++) begin
				if (ph == 0 && sub == 0) begin
					m = 8'hFF;
				end else if (ph == 1 && sub == 0) begin
					m = 8'h00;
				end else begin
					m = 8'($urandom_range(255));
					if ($urandom_range(1)) begin
						m[MODE_TRIM_TRAIL] = 1'b1;
						m[MODE_STRIP_ALL] = 1'b0;
						m[MODE_SQUEEZE] = 1'b0;
					end
				end
				set_mode(m);
				count = 0;
				while (count < 26) begin
					send_random_string($urandom_range(1, 24), $urandom_range(7) != 0, sent);
					count += sent;
				end
			end
		end

		push <= 1'b0;
		while (sb.norm_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
